// ----- sv/complex_arith_unit_assert.svh -----
// ----------------------------------------------------------------------------
// complex_arith_unit_assert: assertion macros
// shorthand for clocked properties checked against clk_i and rst_ni
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg: complex arithmetic unit package
// operation codes, datapath widths, pipeline layout and square root step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cau_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned TOT_W  = 3 * DATA_W;

  localparam int unsigned RAD_W    = PROD_W;
  localparam int unsigned ROOT_W   = DATA_W;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned SQ_STEPS = 4;
  localparam int unsigned SQ_STAGES = ROOT_W / SQ_STEPS;

  // stage 1 multiply, stage 2 sums, stages 3.. root digits, last stage output
  localparam int unsigned SQ_FIRST   = 3;
  localparam int unsigned NUM_STAGES = SQ_FIRST + SQ_STAGES;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_SQUARE = 3'd0,
    KIND_CONJ   = 3'd1,
    KIND_PROD   = 3'd2,
    KIND_MAG    = 3'd3,
    KIND_FMA    = 3'd4,
    KIND_FMS    = 3'd5,
    KIND_SCALE  = 3'd6
  } kind_e;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic                     mag;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     ovf;
  } res_t;

  // one restoring digit of the integer square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    sqrt_t            r;
    cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = REM_W'(cur - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur[REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- sv/complex_arith_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arith_unit: pipelined fixed-point complex ALU
// latency set by the 32-bit square root: 4 root bits per stage
// throughput one word per cycle unless the output stalls; a stalled output only holds full stages
// reset clears the stage valid bits, data registers are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [KIND_W-1:0]        kind_i,
  input  logic signed [DATA_W-1:0] a_re_i,
  input  logic signed [DATA_W-1:0] a_im_i,
  input  logic signed [DATA_W-1:0] b_re_i,
  input  logic signed [DATA_W-1:0] b_im_i,
  input  logic signed [DATA_W-1:0] c_re_i,
  input  logic signed [DATA_W-1:0] c_im_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] res_re_o,
  output logic signed [DATA_W-1:0] res_im_o,
  output logic                     overflow_o
);

  localparam int unsigned Sh2 = 2 * FRAC_BITS;
  localparam logic signed [SUM_W-1:0] HalfSum = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [TOT_W-1:0] HalfTot = TOT_W'(1) <<< (Sh2 - 1);

  function automatic logic [DATA_W:0] sat_tot(input logic signed [TOT_W-1:0] t);
    logic signed [TOT_W-1:0] sh;
    logic                    fits;
    sh   = t >>> Sh2;
    fits = (&sh[TOT_W-1:DATA_W-1]) || !(|sh[TOT_W-1:DATA_W-1]);
    if (fits) begin
      return {1'b0, sh[DATA_W-1:0]};
    end
    return sh[TOT_W-1] ? {1'b1, SAT_MIN} : {1'b1, SAT_MAX};
  endfunction

  // stage valid bits and enables
  logic [NUM_STAGES:1] v_q;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !v_q[NUM_STAGES] || !out_stall_i;
    for (int s = NUM_STAGES - 1; s >= 1; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int s = 2; s <= NUM_STAGES; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // stage 1: operand select and four products
  logic signed [DATA_W-1:0] mx [4];
  logic signed [DATA_W-1:0] my [4];
  logic signed [PROD_W-1:0] prod_d [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mx[i] = '0;
      my[i] = '0;
    end
    unique case (kind_e'(kind_i)) inside
      KIND_SQUARE, KIND_MAG: begin
        mx[0] = a_re_i; my[0] = a_re_i;
        mx[1] = a_im_i; my[1] = a_im_i;
        mx[2] = a_re_i; my[2] = a_im_i;
        mx[3] = a_re_i; my[3] = a_im_i;
      end
      KIND_PROD: begin
        mx[0] = a_re_i; my[0] = b_re_i;
        mx[1] = a_im_i; my[1] = b_im_i;
        mx[2] = a_re_i; my[2] = b_im_i;
        mx[3] = a_im_i; my[3] = b_re_i;
      end
      KIND_FMA, KIND_FMS, KIND_SCALE: begin
        mx[0] = b_re_i; my[0] = c_re_i;
        mx[1] = b_im_i; my[1] = c_im_i;
        mx[2] = b_re_i; my[2] = c_im_i;
        mx[3] = b_im_i; my[3] = c_re_i;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = mx[i] * my[i];
    end
  end

  kind_e                    k1_q;
  logic signed [DATA_W-1:0] ar1_q;
  logic signed [DATA_W-1:0] ai1_q;
  logic signed [PROD_W-1:0] p1_q [4];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      k1_q  <= kind_e'(kind_i);
      ar1_q <= a_re_i;
      ai1_q <= a_im_i;
      for (int i = 0; i < 4; i++) begin
        p1_q[i] <= prod_d[i];
      end
    end
  end

  // stage 2: product sums, scale partial products
  logic signed [SUM_W-1:0]  base_re;
  logic signed [SUM_W-1:0]  base_im;
  logic signed [SUM_W-1:0]  dre;
  logic signed [SUM_W-1:0]  dim;
  logic signed [SUM_W-1:0]  sre_d;
  logic signed [SUM_W-1:0]  sim_d;
  logic signed [DATA_W-1:0] pbc_hi;
  logic [DATA_W-1:0]        pbc_lo;
  logic signed [PROD_W-1:0] sc_d [4];

  always_comb begin
    dre     = SUM_W'(p1_q[0]) - SUM_W'(p1_q[1]);
    dim     = SUM_W'(p1_q[2]) + SUM_W'(p1_q[3]);
    base_re = '0;
    base_im = '0;
    if (k1_q == KIND_FMA || k1_q == KIND_FMS) begin
      base_re = SUM_W'(ar1_q) <<< FRAC_BITS;
      base_im = SUM_W'(ai1_q) <<< FRAC_BITS;
    end
    if (k1_q == KIND_FMS) begin
      sre_d = base_re - dre + HalfSum;
      sim_d = base_im - dim + HalfSum;
    end else if (k1_q == KIND_MAG) begin
      sre_d = SUM_W'(p1_q[0]) + SUM_W'(p1_q[1]);
      sim_d = '0;
    end else begin
      sre_d = base_re + dre + HalfSum;
      sim_d = base_im + dim + HalfSum;
    end
    pbc_hi  = $signed(p1_q[0][PROD_W-1:DATA_W]);
    pbc_lo  = p1_q[0][DATA_W-1:0];
    sc_d[0] = ar1_q * pbc_hi;
    sc_d[1] = ar1_q * $signed({1'b0, pbc_lo});
    sc_d[2] = ai1_q * pbc_hi;
    sc_d[3] = ai1_q * $signed({1'b0, pbc_lo});
  end

  kind_e                    k2_q;
  logic signed [DATA_W-1:0] ar2_q;
  logic signed [DATA_W-1:0] ai2_q;
  logic signed [SUM_W-1:0]  sre2_q;
  logic signed [SUM_W-1:0]  sim2_q;
  logic signed [PROD_W-1:0] sc2_q [4];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      k2_q   <= k1_q;
      ar2_q  <= ar1_q;
      ai2_q  <= ai1_q;
      sre2_q <= sre_d;
      sim2_q <= sim_d;
      for (int i = 0; i < 4; i++) begin
        sc2_q[i] <= sc_d[i];
      end
    end
  end

  // stage 3: align the non-magnitude results to a common scale of 3*FRAC_BITS
  logic signed [TOT_W-1:0] tre_d;
  logic signed [TOT_W-1:0] tim_d;

  always_comb begin
    tre_d = '0;
    tim_d = '0;
    unique case (k2_q) inside
      KIND_SQUARE, KIND_PROD, KIND_FMA, KIND_FMS: begin
        tre_d = TOT_W'(sre2_q) <<< FRAC_BITS;
        tim_d = TOT_W'(sim2_q) <<< FRAC_BITS;
      end
      KIND_CONJ: begin
        tre_d = TOT_W'(ar2_q) <<< Sh2;
        tim_d = (-TOT_W'(ai2_q)) <<< Sh2;
      end
      KIND_SCALE: begin
        tre_d = (TOT_W'(sc2_q[0]) <<< DATA_W) + TOT_W'(sc2_q[1]) + HalfTot;
        tim_d = (TOT_W'(sc2_q[2]) <<< DATA_W) + TOT_W'(sc2_q[3]) + HalfTot;
      end
      default: begin
      end
    endcase
  end

  logic                    mag3_q;
  logic signed [TOT_W-1:0] tre3_q;
  logic signed [TOT_W-1:0] tim3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      mag3_q <= (k2_q == KIND_MAG);
      tre3_q <= tre_d;
      tim3_q <= tim_d;
    end
  end

  // square root stages
  sqrt_t sq_in [SQ_STAGES];
  sqrt_t sq_nx [SQ_STAGES];
  sqrt_t sq_q  [SQ_STAGES];

  always_comb begin
    sqrt_t t;
    sq_in[0] = '{rad: sre2_q[RAD_W-1:0], rem: '0, root: '0};
    for (int k = 1; k < SQ_STAGES; k++) begin
      sq_in[k] = sq_q[k-1];
    end
    for (int k = 0; k < SQ_STAGES; k++) begin
      t = sq_in[k];
      for (int j = 0; j < SQ_STEPS; j++) begin
        t = sqrt_step(t);
      end
      sq_nx[k] = t;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (en[SQ_FIRST+k]) begin
        sq_q[k] <= sq_nx[k];
      end
    end
  end

  // stage 4: saturate, then carry alongside the root
  logic [DATA_W:0] sat_re;
  logic [DATA_W:0] sat_im;
  res_t            car_d;
  res_t            car_q [SQ_FIRST+1:NUM_STAGES-1];

  always_comb begin
    sat_re = sat_tot(tre3_q);
    sat_im = sat_tot(tim3_q);
    car_d  = '{mag: mag3_q, re: sat_re[DATA_W-1:0], im: sat_im[DATA_W-1:0],
               ovf: sat_re[DATA_W] | sat_im[DATA_W]};
  end

  always_ff @(posedge clk_i) begin
    if (en[SQ_FIRST+1]) begin
      car_q[SQ_FIRST+1] <= car_d;
    end
    for (int j = SQ_FIRST + 2; j <= NUM_STAGES - 1; j++) begin
      if (en[j]) begin
        car_q[j] <= car_q[j-1];
      end
    end
  end

  // output stage: round the root and select
  sqrt_t                    sq_last;
  res_t                     car_last;
  logic [ROOT_W:0]          mag_val;
  logic                     mag_ovf;
  logic signed [DATA_W-1:0] res_re_d;
  logic signed [DATA_W-1:0] res_im_d;
  logic                     ovf_d;

  always_comb begin
    sq_last  = sq_q[SQ_STAGES-1];
    car_last = car_q[NUM_STAGES-1];
    mag_val  = {1'b0, sq_last.root}
             + (ROOT_W+1)'(sq_last.rem > REM_W'(sq_last.root));
    mag_ovf  = mag_val > {1'b0, SAT_MAX};
    if (car_last.mag) begin
      res_re_d = mag_ovf ? SAT_MAX : mag_val[DATA_W-1:0];
      res_im_d = '0;
      ovf_d    = mag_ovf;
    end else begin
      res_re_d = car_last.re;
      res_im_d = car_last.im;
      ovf_d    = car_last.ovf;
    end
  end

  logic signed [DATA_W-1:0] res_re_q;
  logic signed [DATA_W-1:0] res_im_q;
  logic                     ovf_q;

  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES]) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      ovf_q    <= ovf_d;
    end
  end

  assign out_valid_o = v_q[NUM_STAGES];
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign overflow_o  = ovf_q;

`include "complex_arith_unit_assert.svh"

  `CAU_ASSERT_IMP(a_stall_full, in_stall_o, (&v_q) && out_stall_i, "input stalled with a bubble in the pipe")
  `CAU_ASSERT_NXT(a_accept_s1, in_valid_i && !in_stall_o, v_q[1], "accepted word not in stage 1")
  `CAU_ASSERT_IMP(a_ovf_sat, out_valid_o && overflow_o, res_re_o == SAT_MAX || res_re_o == SAT_MIN || res_im_o == SAT_MAX || res_im_o == SAT_MIN, "overflow without saturated part")

endmodule

// ----- test/tb_complex_arith_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arith_unit: self-checking bench for the complex arithmetic unit
// a directed table (extremes, every kind, rounding ties, saturation, the unused
// kind) followed by random words; every accepted word is predicted in the bench
// and compared field by field with the results, in order, while both sides
// idle at random and the receiver once holds off long enough to fill the pipe
// ----------------------------------------------------------------------------

module tb_complex_arith_unit;
  import cau_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int RANDOM_WORDS   = 800;
  localparam int LATENCY        = 11;
  localparam int LONG_HOLD      = 500;
  localparam int CYCLE_LIMIT    = 200000;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  localparam logic signed [DATA_W-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [127:0]      TOP  = 128'sd2147483647;
  localparam logic signed [127:0]      BOT  = -128'sd2147483648;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
    logic signed [DATA_W-1:0] c_re;
    logic signed [DATA_W-1:0] c_im;
  } alu_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     ovf;
  } cx_result_t;

  typedef struct packed {
    alu_word_t  word;
    logic       known;
    cx_result_t result;
  } plan_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [KIND_W-1:0]        kind_i;
  logic signed [DATA_W-1:0] a_re_i;
  logic signed [DATA_W-1:0] a_im_i;
  logic signed [DATA_W-1:0] b_re_i;
  logic signed [DATA_W-1:0] b_im_i;
  logic signed [DATA_W-1:0] c_re_i;
  logic signed [DATA_W-1:0] c_im_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] res_re_o;
  logic signed [DATA_W-1:0] res_im_o;
  logic                     overflow_o;

  cx_result_t pending_results[$];
  plan_row_t  directed_rows[$];
  int         errors      = 0;
  int         cycle_count = 0;
  int         words_seen  = 0;
  bit         draining    = 1'b0;

  complex_arith_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .a_re_i      (a_re_i),
    .a_im_i      (a_im_i),
    .b_re_i      (b_re_i),
    .b_im_i      (b_im_i),
    .c_re_i      (c_re_i),
    .c_im_i      (c_im_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_re_o    (res_re_o),
    .res_im_o    (res_im_o),
    .overflow_o  (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] root_to_nearest(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = n;
    root  = '0;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  function automatic logic [32:0] clamp32(logic signed [127:0] v);
    if (v > TOP) return {1'b1, SAT_MAX};
    if (v < BOT) return {1'b1, SAT_MIN};
    return {1'b0, v[31:0]};
  endfunction

  // exact sums in 128 bits, one rounding (ties up), then saturation
  function automatic cx_result_t complex_op_result(alu_word_t w);
    logic signed [127:0] ar, ai, br, bi, cr, ci;
    logic signed [127:0] sum_re, sum_im, rnd_re, rnd_im;
    logic [63:0]         mag;
    logic [32:0]         sat_re, sat_im;
    int                  shift;
    cx_result_t          r;
    ar = $signed(w.a_re);
    ai = $signed(w.a_im);
    br = $signed(w.b_re);
    bi = $signed(w.b_im);
    cr = $signed(w.c_re);
    ci = $signed(w.c_im);
    shift  = FRAC;
    sum_re = '0;
    sum_im = '0;
    case (w.kind)
      KIND_SQUARE: begin
        sum_re = ar * ar - ai * ai;
        sum_im = ar * ai + ar * ai;
      end
      KIND_CONJ: begin
        sum_re = ar <<< FRAC;
        sum_im = (-ai) <<< FRAC;
      end
      KIND_PROD: begin
        sum_re = ar * br - ai * bi;
        sum_im = ar * bi + ai * br;
      end
      KIND_MAG: begin
        mag    = root_to_nearest(64'(ar * ar + ai * ai));
        sum_re = $signed({64'd0, mag}) <<< FRAC;
      end
      KIND_FMA: begin
        sum_re = (ar <<< FRAC) + br * cr - bi * ci;
        sum_im = (ai <<< FRAC) + br * ci + bi * cr;
      end
      KIND_FMS: begin
        sum_re = (ar <<< FRAC) - br * cr + bi * ci;
        sum_im = (ai <<< FRAC) - br * ci - bi * cr;
      end
      KIND_SCALE: begin
        sum_re = ar * br * cr;
        sum_im = ai * br * cr;
        shift  = 2 * FRAC;
      end
      default: begin
      end
    endcase
    rnd_re = (sum_re + (128'sd1 <<< (shift - 1))) >>> shift;
    rnd_im = (sum_im + (128'sd1 <<< (shift - 1))) >>> shift;
    sat_re = clamp32(rnd_re);
    sat_im = clamp32(rnd_im);
    r.re   = sat_re[31:0];
    r.im   = sat_im[31:0];
    r.ovf  = sat_re[32] | sat_im[32];
    return r;
  endfunction

  function automatic plan_row_t plan_row(logic [KIND_W-1:0] kind,
      logic signed [DATA_W-1:0] ar, logic signed [DATA_W-1:0] ai,
      logic signed [DATA_W-1:0] br, logic signed [DATA_W-1:0] bi,
      logic signed [DATA_W-1:0] cr, logic signed [DATA_W-1:0] ci, logic known,
      logic signed [DATA_W-1:0] er, logic signed [DATA_W-1:0] ei, logic eo);
    plan_row_t p;
    p.word   = '{kind, ar, ai, br, bi, cr, ci};
    p.known  = known;
    p.result = '{er, ei, eo};
    return p;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_part();
    logic [31:0] v;
    logic [31:0] r;
    r = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      7: begin
        case ($urandom_range(0, 5))
          0:       v = SAT_MAX;
          1:       v = SAT_MIN;
          2:       v = '0;
          3:       v = ONE;
          4:       v = -ONE;
          default: v = 32'd1;
        endcase
      end
      8:       v = ($urandom_range(0, 63) - 32'd32) << 15;
      default: v = $urandom_range(0, 1) ? SAT_MAX - r : SAT_MIN + r;
    endcase
    return v;
  endfunction

  task automatic send_word(alu_word_t w, cx_result_t expected, int gap);
    bit taken;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= w.kind;
    a_re_i     <= w.a_re;
    a_im_i     <= w.a_im;
    b_re_i     <= w.b_re;
    b_im_i     <= w.b_im;
    c_re_i     <= w.c_re;
    c_im_i     <= w.c_im;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) pending_results.push_back(expected);
      @(posedge clk_i);
    end
  endtask

  initial begin
    alu_word_t  w;
    cx_result_t e;
    int         gap;
    int         k;
    in_valid_i <= 1'b0;
    kind_i     <= '0;
    a_re_i     <= '0;
    a_im_i     <= '0;
    b_re_i     <= '0;
    b_im_i     <= '0;
    c_re_i     <= '0;
    c_im_i     <= '0;

    directed_rows.push_back(plan_row(KIND_SQUARE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_SQUARE, 3 * ONE, 2 * ONE, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_SQUARE, SAT_MIN, 0, 0, 0, 0, 0,
                                     1, SAT_MAX, 0, 1));
    directed_rows.push_back(plan_row(KIND_SQUARE, SAT_MAX, SAT_MAX, 0, 0, 0, 0,
                                     0, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_CONJ, ONE, 2 * ONE, 0, 0, 0, 0,
                                     1, ONE, 32'shFFFE_0000, 0));
    directed_rows.push_back(plan_row(KIND_CONJ, SAT_MAX, SAT_MIN, 0, 0, 0, 0,
                                     1, SAT_MAX, SAT_MAX, 1));
    directed_rows.push_back(plan_row(KIND_CONJ, SAT_MIN, SAT_MAX, 0, 0, 0, 0,
                                     1, SAT_MIN, 32'sh8000_0001, 0));
    directed_rows.push_back(plan_row(KIND_PROD, ONE, 0, SAT_MAX, SAT_MIN, 0, 0,
                                     1, SAT_MAX, SAT_MIN, 0));
    directed_rows.push_back(plan_row(KIND_PROD, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 0, 0,
                                     1, 0, SAT_MAX, 1));
    // rounding ties go toward plus infinity
    directed_rows.push_back(plan_row(KIND_PROD, 1, 0, 32'sh8000, 0, 0, 0, 1, 1, 0, 0));
    directed_rows.push_back(plan_row(KIND_PROD, -1, 0, 32'sh8000, 0, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_PROD, 32'sh0003_8000, -32'sh0001_4000,
                                     32'sh0002_0000, 32'sh0000_C000, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0,
                                     1, 5 * ONE, 0, 0));
    directed_rows.push_back(plan_row(KIND_MAG, SAT_MIN, SAT_MIN, 0, 0, 0, 0,
                                     1, SAT_MAX, 0, 1));
    directed_rows.push_back(plan_row(KIND_MAG, SAT_MAX, 0, 0, 0, 0, 0, 1, SAT_MAX, 0, 0));
    directed_rows.push_back(plan_row(KIND_MAG, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_MAG, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_FMA, ONE, 2 * ONE, 0, 0, SAT_MAX, SAT_MIN,
                                     1, ONE, 2 * ONE, 0));
    directed_rows.push_back(plan_row(KIND_FMA, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                                     SAT_MAX, SAT_MAX, 0, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_FMS, SAT_MAX, SAT_MIN, SAT_MIN, 0, SAT_MIN, 0,
                                     1, SAT_MIN, SAT_MIN, 1));
    directed_rows.push_back(plan_row(KIND_FMS, ONE, -ONE, 32'sh0001_8000, ONE,
                                     -32'sh8000, 3 * ONE, 0, 0, 0, 0));
    directed_rows.push_back(plan_row(KIND_SCALE, ONE, -ONE, 2 * ONE, SAT_MIN,
                                     3 * ONE, SAT_MAX, 1, 6 * ONE, -6 * ONE, 0));
    directed_rows.push_back(plan_row(KIND_SCALE, SAT_MAX, SAT_MIN, SAT_MAX, 0,
                                     SAT_MAX, 0, 1, SAT_MAX, SAT_MIN, 1));
    directed_rows.push_back(plan_row(KIND_SCALE, 1, -1, 32'sh8000, 0, ONE, 0, 1, 1, 0, 0));
    directed_rows.push_back(plan_row(KIND_UNUSED, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                                     SAT_MAX, SAT_MAX, 1, 0, 0, 0));

    wait (rst_ni);
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      e = directed_rows[i].known ? directed_rows[i].result
                                 : complex_op_result(directed_rows[i].word);
      send_word(directed_rows[i].word, e, $urandom_range(0, 19));
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      k      = $urandom_range(0, 19);
      w.kind = (k == 19) ? KIND_UNUSED : KIND_W'(k % 7);
      w.a_re = random_part();
      w.a_im = random_part();
      w.b_re = random_part();
      w.b_im = random_part();
      w.c_re = random_part();
      w.c_im = random_part();
      // every third run of forty words goes back to back
      gap = ((i / 40) % 3 == 1) ? 0 : $urandom_range(0, 19);
      send_word(w, complex_op_result(w), gap);
    end

    in_valid_i <= 1'b0;
    draining = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3 * LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    int         hold;
    bit         taken;
    cx_result_t e;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (draining || (words_seen / 64) % 3 == 0) hold = 0;
      else hold = $urandom_range(0, 19);
      // long hold-off so the pipe fills and pushes back on the sender
      if (words_seen == 100) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk_i);
        if (out_valid_o) begin
          taken = 1'b1;
          if (pending_results.size() == 0) begin
            $error("unexpected word: res_re %h res_im %h overflow %b",
                   res_re_o, res_im_o, overflow_o);
            errors++;
          end else begin
            e = pending_results.pop_front();
            if (res_re_o !== e.re) begin
              $error("res_re: expected %h, got %h", e.re, res_re_o);
              errors++;
            end
            if (res_im_o !== e.im) begin
              $error("res_im: expected %h, got %h", e.im, res_im_o);
              errors++;
            end
            if (overflow_o !== e.ovf) begin
              $error("overflow: expected %b, got %b", e.ovf, overflow_o);
              errors++;
            end
          end
        end
        @(posedge clk_i);
      end
      words_seen++;
    end
  end

endmodule
